/* hw/rtl/usr_pkg.sv */
// Shared types, constants and register codes for the ultrasonic ranger.
`default_nettype none

package usr_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 14;

    localparam int THRESH_W  = 12;
    localparam int DUTY_W    = 8;
    localparam int PERIOD_W  = 8;
    localparam int MEASURE_W = 14;
    localparam int DIST_W    = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_DUTY      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_DUTY       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_PERIOD = 3'd4;

    localparam logic [THRESH_W-1:0]  NEAR_THRESHOLD_RESET = 12'd5;
    localparam logic [DUTY_W-1:0]    NEAR_DUTY_RESET      = 8'd6;
    localparam logic [DUTY_W-1:0]    FAR_DUTY_RESET       = 8'd24;
    localparam logic [PERIOD_W-1:0]  PWM_PERIOD_RESET     = 8'd200;
    localparam logic [MEASURE_W-1:0] MEASURE_PERIOD_RESET = 14'd10000;

    // distance = floor(count * 17 / 100), done as count * 17 * ceil(2^26 / 100) >> 26;
    // exact for every count below the saturation point
    localparam int                DIST_MUL_OP_W  = 15;
    localparam logic [DIST_MUL_OP_W-1:0] DIST_SAT_COUNT = 15'd24095;
    localparam int                DIST_MUL_W     = 24;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL   = 24'd11408513;
    localparam int                DIST_SHIFT     = 26;
    localparam int                DIST_PROD_W    = DIST_MUL_OP_W + DIST_MUL_W;

    typedef struct packed {
        logic [MEASURE_W-1:0] measure_period;
        logic [PERIOD_W-1:0]  pwm_period;
        logic [DUTY_W-1:0]    far_duty;
        logic [DUTY_W-1:0]    near_duty;
        logic [THRESH_W-1:0]  near_threshold;
    } cfg_t;

    typedef struct packed {
        logic echo_level;
        logic coarse_tick;
        logic fine_tick;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic              distance_valid;
        logic              pwm_out;
        logic              trigger_out;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/usr_cfg_regs.sv */
// Configuration register file of the ultrasonic ranger.
`default_nettype none

module usr_cfg_regs
    import usr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_NEAR_THRESHOLD: cfg_next.near_threshold = wr_data[THRESH_W-1:0];
                REG_NEAR_DUTY:      cfg_next.near_duty      = wr_data[DUTY_W-1:0];
                REG_FAR_DUTY:       cfg_next.far_duty       = wr_data[DUTY_W-1:0];
                REG_PWM_PERIOD:     cfg_next.pwm_period     = wr_data[PERIOD_W-1:0];
                REG_MEASURE_PERIOD: cfg_next.measure_period = wr_data[MEASURE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= NEAR_THRESHOLD_RESET;
            cfg_reg.near_duty      <= NEAR_DUTY_RESET;
            cfg_reg.far_duty       <= FAR_DUTY_RESET;
            cfg_reg.pwm_period     <= PWM_PERIOD_RESET;
            cfg_reg.measure_period <= MEASURE_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hw/rtl/usr_core.sv */
// Measurement, distance and PWM state with the per-tick update logic.
`default_nettype none

module usr_core
    import usr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam int CMP_W  = (COUNT_WIDTH > MEASURE_W) ? COUNT_WIDTH : MEASURE_W;
    localparam int DCMP_W = (COUNT_WIDTH > DIST_MUL_OP_W) ? COUNT_WIDTH : DIST_MUL_OP_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_TWO = COUNT_WIDTH'(2);

    logic [COUNT_WIDTH-1:0] period_count_reg, period_count_next;
    logic [COUNT_WIDTH-1:0] echo_count_reg, echo_count_next;
    logic                   trigger_level_reg, trigger_level_next;
    logic                   reported_reg, reported_next;
    logic [PERIOD_W-1:0]    pwm_count_reg, pwm_count_next;
    logic                   pwm_level_reg, pwm_level_next;
    logic [DUTY_W-1:0]      current_duty_reg, current_duty_next;
    logic [DIST_W-1:0]      last_distance_reg, last_distance_next;

    logic [COUNT_WIDTH-1:0]   period_inc;
    logic [DIST_PROD_W-1:0]   dist_prod;
    logic [DIST_W-1:0]        dist_value;
    logic                     report;
    logic [PERIOD_W:0]        pwm_inc;

    always_comb
    begin
        period_count_next  = period_count_reg;
        echo_count_next    = echo_count_reg;
        trigger_level_next = trigger_level_reg;
        reported_next      = reported_reg;
        period_inc         = period_count_reg + COUNT_ONE;

        if (item.fine_tick)
        begin
            period_count_next = period_inc;
            if (period_inc == COUNT_ONE)
            begin
                trigger_level_next = 1'b1;
            end
            else if (period_inc == COUNT_TWO)
            begin
                trigger_level_next = 1'b0;
            end
            if (item.echo_level && (echo_count_reg != COUNT_MAX))
            begin
                echo_count_next = echo_count_reg + COUNT_ONE;
            end
            // restart the measurement period
            if (CMP_W'(period_inc) >= CMP_W'(cfg.measure_period))
            begin
                period_count_next = '0;
                echo_count_next   = '0;
                reported_next     = 1'b0;
            end
        end
    end

    // saturate at the top of the distance range, else scale by 0.17
    assign dist_prod = DIST_PROD_W'(DIST_MUL_OP_W'(echo_count_next))
                     * DIST_PROD_W'(DIST_MUL);

    always_comb
    begin
        if (DCMP_W'(echo_count_next) >= DCMP_W'(DIST_SAT_COUNT))
        begin
            dist_value = '1;
        end
        else
        begin
            dist_value = dist_prod[DIST_SHIFT +: DIST_W];
        end
    end

    assign report = !item.echo_level && (echo_count_next != '0) && !reported_next;

    always_comb
    begin
        last_distance_next = last_distance_reg;
        current_duty_next  = current_duty_reg;
        if (report)
        begin
            last_distance_next = dist_value;
            current_duty_next  = (dist_value < cfg.near_threshold) ? cfg.near_duty
                                                                   : cfg.far_duty;
        end
    end

    always_comb
    begin
        pwm_count_next = pwm_count_reg;
        pwm_level_next = pwm_level_reg;
        pwm_inc        = {1'b0, pwm_count_reg} + (PERIOD_W+1)'(1);
        if (item.coarse_tick)
        begin
            priority if (pwm_inc <= {1'b0, current_duty_next})
            begin
                pwm_level_next = 1'b1;
                pwm_count_next = pwm_inc[PERIOD_W-1:0];
            end
            else if (pwm_inc < {1'b0, cfg.pwm_period})
            begin
                pwm_level_next = 1'b0;
                pwm_count_next = pwm_inc[PERIOD_W-1:0];
            end
            else
            begin
                pwm_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg  <= '0;
            echo_count_reg    <= '0;
            trigger_level_reg <= 1'b0;
            reported_reg      <= 1'b0;
            pwm_count_reg     <= '0;
            pwm_level_reg     <= 1'b0;
            current_duty_reg  <= FAR_DUTY_RESET;
            last_distance_reg <= '0;
        end
        else if (advance)
        begin
            period_count_reg  <= period_count_next;
            echo_count_reg    <= echo_count_next;
            trigger_level_reg <= trigger_level_next;
            reported_reg      <= report ? 1'b1 : reported_next;
            pwm_count_reg     <= pwm_count_next;
            pwm_level_reg     <= pwm_level_next;
            current_duty_reg  <= current_duty_next;
            last_distance_reg <= last_distance_next;
        end
    end

    assign result.trigger_out    = trigger_level_next;
    assign result.pwm_out        = pwm_level_next;
    assign result.distance_valid = report;
    assign result.distance_cm    = last_distance_next;

endmodule

`default_nettype wire

/* hw/rtl/ultrasonic_ranger_with_pwm_drive_unit.sv */
// Ultrasonic ranger with trigger generation, distance report and servo PWM.
//
// One tick request enters on the s_ stream each cycle unless the stream is
// stalled: fine tick, coarse tick and the sampled echo level. Each request
// gives exactly one result on the m_ stream: trigger level, PWM level, a
// distance-valid flag and the distance. A request is held in the input
// register; when it advances it updates the counters and lands in the output
// register, so throughput is 1 request per cycle while the receiver keeps up.
// When the receiver stalls, the result holds in the output register and one
// more request is taken into the input register; s_tready then drops until
// m_tready returns. Nothing is lost or repeated.
// Configuration writes on the cfg_ channel are always taken (cfg_ready high);
// write only while no request is in flight. An unknown index is ignored.
// Reset clears all counters and levels, loads the register defaults and the
// far duty as current duty; both stream stages come up empty.
`default_nettype none

module ultrasonic_ranger_with_pwm_drive_unit
    import usr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [0] fine_tick, [1] coarse_tick, [2] echo_level, [7:3] zero
    input  wire logic [7:0]             s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] trigger_out, [1] pwm_out, [2] distance_valid, [14:3] distance_cm, [15] zero
    output logic [15:0]                 m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    advance;
    logic    in_accept;
    cfg_t    cfg;
    result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    usr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    usr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= s_tdata[2:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

`ifndef NO_ASSERTIONS
    // input stalls only when both stages hold a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low with a free stage");

    // a request moved forward shows up on the output next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced request missing at output");

    // a held request stays in the input register
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending request dropped or changed");
`endif

endmodule

`default_nettype wire

/* test/ultrasonic_ranger_with_pwm_drive_unit_test.sv */
// Self-checking testbench for the ultrasonic ranger: tick requests in, predicted results compared.
`timescale 1ns / 100ps

module ultrasonic_ranger_with_pwm_drive_unit_test;

    import usr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 40;

    localparam int COUNT_W  = COUNT_WIDTH_DEFAULT;
    localparam int RESULT_W = $bits(result_t);
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [COUNT_W-1:0] ECHO_COUNT_MAX  = '1;
    localparam int unsigned        CM_PER_TICK_NUM = 17;
    localparam int unsigned        CM_PER_TICK_DEN = 100;
    localparam int unsigned        DISTANCE_MAX    = (1 << DIST_W) - 1;
    localparam int unsigned        THRESH_TOP      = (1 << THRESH_W) - 1;
    localparam int unsigned        DUTY_TOP        = (1 << DUTY_W) - 1;
    localparam int unsigned        PERIOD_TOP      = (1 << PERIOD_W) - 1;
    localparam int unsigned        MEASURE_TOP     = (1 << MEASURE_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predicted block state
    cfg_t                 ranger_regs;
    logic [COUNT_W-1:0]   period_count;
    logic [COUNT_W-1:0]   echo_count;
    logic                 trigger_level;
    logic                 reported;
    logic [PERIOD_W-1:0]  pwm_count;
    logic                 pwm_level;
    logic [DUTY_W-1:0]    current_duty;
    logic [DIST_W-1:0]    last_distance;
    result_t              pending_results[$];

    int mismatch_count    = 0;
    int ticks_accepted    = 0;
    int results_checked   = 0;
    int distance_reports  = 0;
    int settings_written  = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_off_cycles   = 0;
    int echo_wait         = 0;
    int echo_len          = 0;

    ultrasonic_ranger_with_pwm_drive_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic result_t advance_ranger(item_t req);
        result_t     res;
        int unsigned distance;
        int unsigned pwm_next;
        res = '0;
        if (req.fine_tick)
        begin
            period_count = period_count + 1'b1;
            if (period_count == COUNT_W'(1))
                trigger_level = 1'b1;
            else if (period_count == COUNT_W'(2))
                trigger_level = 1'b0;
            if (req.echo_level && echo_count != ECHO_COUNT_MAX)
                echo_count = echo_count + 1'b1;
            // restart the measurement window
            if (period_count >= ranger_regs.measure_period)
            begin
                period_count = '0;
                echo_count   = '0;
                reported     = 1'b0;
            end
        end
        // report once per window, as soon as echo has fallen
        if (!req.echo_level && echo_count != '0 && !reported)
        begin
            distance = echo_count * CM_PER_TICK_NUM / CM_PER_TICK_DEN;
            if (distance > DISTANCE_MAX)
                distance = DISTANCE_MAX;
            last_distance = DIST_W'(distance);
            current_duty  = (distance < ranger_regs.near_threshold) ? ranger_regs.near_duty
                                                                    : ranger_regs.far_duty;
            reported = 1'b1;
            res.distance_valid = 1'b1;
        end
        if (req.coarse_tick)
        begin
            pwm_next = pwm_count + 1;
            if (pwm_next <= current_duty)
            begin
                pwm_level = 1'b1;
                pwm_count = PERIOD_W'(pwm_next);
            end
            else if (pwm_next < ranger_regs.pwm_period)
            begin
                pwm_level = 1'b0;
                pwm_count = PERIOD_W'(pwm_next);
            end
            else
                pwm_count = '0;
        end
        res.trigger_out = trigger_level;
        res.pwm_out     = pwm_level;
        res.distance_cm = last_distance;
        return res;
    endfunction

    function automatic item_t make_tick(logic fine, logic coarse, logic echo);
        item_t req;
        req.fine_tick   = fine;
        req.coarse_tick = coarse;
        req.echo_level  = echo;
        return req;
    endfunction

    // mostly sensor-like echo pulses with random tick timing, some noise
    function automatic item_t random_tick();
        item_t req;
        req.fine_tick   = ($urandom_range(99) < 75);
        req.coarse_tick = 1'($urandom_range(1));
        if ($urandom_range(99) < 15)
            req.echo_level = 1'($urandom_range(1));
        else if (echo_len > 0)
        begin
            req.echo_level = 1'b1;
            if (req.fine_tick)
                echo_len--;
        end
        else
        begin
            req.echo_level = 1'b0;
            if (echo_wait > 0)
                echo_wait--;
            else
            begin
                echo_wait = $urandom_range(6, 1);
                echo_len  = $urandom_range(30, 1);
            end
        end
        return req;
    endfunction

    function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                                 int unsigned top);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return top;
        return $urandom_range(hi, lo);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     results_checked, what, got, want);
    endtask

    // track accepted requests and register writes, check every result
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NEAR_THRESHOLD: ranger_regs.near_threshold = cfg_data[THRESH_W-1:0];
                    REG_NEAR_DUTY:      ranger_regs.near_duty      = cfg_data[DUTY_W-1:0];
                    REG_FAR_DUTY:       ranger_regs.far_duty       = cfg_data[DUTY_W-1:0];
                    REG_PWM_PERIOD:     ranger_regs.pwm_period     = cfg_data[PERIOD_W-1:0];
                    REG_MEASURE_PERIOD: ranger_regs.measure_period = cfg_data[MEASURE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_ranger(item_t'(s_tdata[$bits(item_t)-1:0]));
                pending_results.push_back(want);
                ticks_accepted++;
                if (want.distance_valid)
                    distance_reports++;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, tdata", m_tdata, 0);
                else
                begin
                    want = pending_results.pop_front();
                    got  = result_t'(m_tdata[RESULT_W-1:0]);
                    if (got.trigger_out !== want.trigger_out)
                        report_mismatch("trigger_out", got.trigger_out, want.trigger_out);
                    if (got.pwm_out !== want.pwm_out)
                        report_mismatch("pwm_out", got.pwm_out, want.pwm_out);
                    if (got.distance_valid !== want.distance_valid)
                        report_mismatch("distance_valid", got.distance_valid,
                                        want.distance_valid);
                    if (got.distance_cm !== want.distance_cm)
                        report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
                    if (m_tdata[M_DATA_W-1:RESULT_W] !== '0)
                        report_mismatch("tdata padding", m_tdata[M_DATA_W-1:RESULT_W], 0);
                    results_checked++;
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("run stopped at the cycle limit, %0d results still pending",
                 pending_results.size());
        $display("** ultrasonic_ranger_with_pwm_drive_unit: FAILED **");
        $finish;
    end

    // leaves tvalid high; a drain, or an idle gap in the next call, lowers it
    task automatic send_tick(item_t req);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(req);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] reg_index, int unsigned reg_value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= CFG_DATA_W'(reg_value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write every register on an idle block, plus one write to an unused index
    task automatic write_settings(int unsigned thr, int unsigned near_d, int unsigned far_d,
                                  int unsigned pwm_per, int unsigned meas_per);
        logic [CFG_INDEX_W-1:0] junk_index;
        junk_index = CFG_INDEX_W'($urandom_range(REG_INDEX_TOP, REG_MEASURE_PERIOD + 1));
        wait_drained();
        write_register(REG_NEAR_THRESHOLD, thr);
        write_register(REG_NEAR_DUTY, near_d);
        write_register(REG_FAR_DUTY, far_d);
        write_register(REG_PWM_PERIOD, pwm_per);
        write_register(REG_MEASURE_PERIOD, meas_per);
        write_register(junk_index, $urandom);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    task automatic test_reset_defaults();
        for (int combo = 0; combo < 8; combo++)
            send_tick(item_t'(combo[2:0]));
        // echo falls with a count of two: distance rounds down to zero
        send_tick(make_tick(1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_measurement_window();
        write_settings(2, 1, 3, 4, 20);
        send_tick(make_tick(1'b1, 1'b1, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0));
        for (int k = 0; k < 8; k++)
            send_tick(make_tick(1'b1, k[0], 1'b1));
        send_tick(make_tick(1'b0, 1'b1, 1'b0));
        // echo stays low: no second report in the same window
        send_tick(make_tick(1'b1, 1'b1, 1'b0));
        repeat (9) send_tick(make_tick(1'b1, 1'b1, 1'b0));
        // echo without fine ticks counts nothing, so nothing to report
        send_tick(make_tick(1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b1, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_odd_settings();
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0:       write_settings(0, 0, 0, 0, 0);
                1:       write_settings(THRESH_TOP, DUTY_TOP, DUTY_TOP, 1, 1);
                2:       write_settings(1, 3, DUTY_TOP, 2, 2);
                default: write_settings(0, DUTY_TOP, 0, PERIOD_TOP, MEASURE_TOP);
            endcase
            repeat (16) send_tick(random_tick());
        end
    endtask

    task automatic test_backpressure();
        write_settings(5, 2, 9, 12, 24);
        hold_off_cycles = 60;
        repeat (30) send_tick(random_tick());
    endtask

    task automatic test_random_ranging(int n_sets, int per_set);
        for (int s = 0; s < n_sets; s++)
        begin
            write_settings(pick_setting(0, 12, THRESH_TOP), pick_setting(0, 12, DUTY_TOP),
                           pick_setting(0, 12, DUTY_TOP), pick_setting(2, 12, PERIOD_TOP),
                           pick_setting(8, 48, MEASURE_TOP));
            repeat (per_set) send_tick(random_tick());
        end
    endtask

    // one long echo, then run on with echo low and a short echo after it
    task automatic test_long_echo();
        write_settings(3000, 200, 10, PERIOD_TOP, MEASURE_TOP);
        send_tick(make_tick(1'b1, 1'b0, 1'b0));
        repeat (150) send_tick(make_tick(1'b1, 1'($urandom_range(1)), 1'b1));
        send_tick(make_tick(1'b1, 1'b0, 1'b0));
        repeat (20) send_tick(make_tick(1'b1, 1'($urandom_range(1)), 1'b0));
        repeat (10) send_tick(make_tick(1'b1, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b1, 1'b0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        ranger_regs.near_threshold = NEAR_THRESHOLD_RESET;
        ranger_regs.near_duty      = NEAR_DUTY_RESET;
        ranger_regs.far_duty       = FAR_DUTY_RESET;
        ranger_regs.pwm_period     = PWM_PERIOD_RESET;
        ranger_regs.measure_period = MEASURE_PERIOD_RESET;
        period_count  = '0;
        echo_count    = '0;
        trigger_level = 1'b0;
        reported      = 1'b0;
        pwm_count     = '0;
        pwm_level     = 1'b0;
        current_duty  = FAR_DUTY_RESET;
        last_distance = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle_pct   = 30;
        receiver_idle_pct = 59;
        test_reset_defaults();
        test_measurement_window();
        test_odd_settings();
        test_backpressure();
        test_random_ranging(4, 30);

        sender_idle_pct   = 59;
        receiver_idle_pct = 30;
        test_random_ranging(4, 30);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_ranging(4, 30);
        test_long_echo();
        wait_drained();

        $display("covered %0d tick requests over %0d register settings, %0d distance reports",
                 ticks_accepted, settings_written, distance_reports);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("** ultrasonic_ranger_with_pwm_drive_unit: PASSED **");
        else
            $display("** ultrasonic_ranger_with_pwm_drive_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/usr_pkg.sv
hw/rtl/usr_cfg_regs.sv
hw/rtl/usr_core.sv
hw/rtl/ultrasonic_ranger_with_pwm_drive_unit.sv
test/ultrasonic_ranger_with_pwm_drive_unit_test.sv
